// ----- src/tq_pkg.sv -----
// Package for the timed token pipeline queue.
// Holds opcode, status, register index and state codes, the stored slot
// layout and the controller command struct. No dependencies.
package tq_pkg;

    localparam int TIME_W   = 48;
    localparam int CMD_ID_W = 16;
    localparam int INDEX_W  = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACCEPT_GATED = 3'd0,
        OP_ACCEPT_ADD   = 3'd1,
        OP_TAKE_READY   = 3'd2,
        OP_CLEAR        = 3'd3,
        OP_QUERY        = 3'd4
    } tq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_REFUSED_FULL  = 2'd1,
        ST_REFUSED_GATE  = 2'd2,
        ST_NOTHING_READY = 2'd3
    } tq_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILL_LATENCY = 2'd0,
        CFG_INIT_INTERVAL = 2'd1
    } tq_cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_EXEC,
        S_SETTLE,
        S_FLAGS,
        S_RESP
    } tq_state_t;

    // One stored token
    typedef struct packed {
        logic [CMD_ID_W-1:0] command_id;
        logic [INDEX_W-1:0]  element_index;
        logic                last_mark;
        logic [TIME_W-1:0]   ready_time;
    } tq_slot_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic do_prep;
        logic do_exec;
        logic do_flags;
    } tq_cmd_t;

    // Saturating time add: t + d, held at the largest timestamp
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                   input logic [CFG_W-1:0] d);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + {{(TIME_W+1-CFG_W){1'b0}}, d};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

endpackage

// ----- src/tq_in_if.sv -----
// Input channel of the timed token pipeline queue: valid/ready plus one request.
// Depends on tq_pkg for field widths.
interface tq_in_if;
    import tq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CMD_ID_W-1:0] command_id;
    logic [INDEX_W-1:0]  element_index;
    logic                last_flag;
    logic [TIME_W-1:0]   now;

    modport source (output valid, opcode, command_id, element_index, last_flag, now,
                    input ready);
    modport sink   (input valid, opcode, command_id, element_index, last_flag, now,
                    output ready);
endinterface

// ----- src/tq_out_if.sv -----
// Result channel of the timed token pipeline queue: valid/ready plus one result.
// Depends on tq_pkg for field widths; OCC_W follows the queue depth.
interface tq_out_if #(parameter int OCC_W = 5);
    import tq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                token_valid;
    logic [CMD_ID_W-1:0] token_command_id;
    logic [INDEX_W-1:0]  token_index;
    logic                token_last;
    logic [OCC_W-1:0]    in_flight;
    logic                can_accept_now;
    logic                queue_full;
    logic                head_ready;

    modport source (output valid, status, token_valid, token_command_id, token_index,
                    token_last, in_flight, can_accept_now, queue_full, head_ready,
                    input ready);
    modport sink   (input valid, status, token_valid, token_command_id, token_index,
                    token_last, in_flight, can_accept_now, queue_full, head_ready,
                    output ready);
endinterface

// ----- src/timed_token_pipeline_queue.sv -----
// Top level of the timed token pipeline queue: joins controller and datapath.
// Depends on tq_pkg, tq_in_if, tq_out_if, tq_ctrl and tq_datapath.
//
// Usage: each transaction on in_ch carries an opcode (gated accept, additional
// accept, take ready, clear, query) with a token's command id, element index,
// last mark and the current timestamp. Exactly one result follows on out_ch:
// status, the popped token (zero when none), tokens in flight after the
// operation, and whether a gated accept would succeed, the queue is full and
// the head token is ready at that timestamp.
// Sequence: after the input transaction come the time add, execute, memory read
// settle and flag evaluation phases, then the response phase holds the result
// until it is taken; the next input is taken in the cycle after the result
// transaction at the earliest, so a new request is not taken before the last
// result is taken. The slot memory read at the head pointer is what needs the
// settle phase.
// Reset: empties the queue, disarms the interval gate and sets both registers
// to one. The slot memory is not cleared; only held slots are ever used.
// Stall: while out_ch.ready is low the result holds and in_ch.ready stays low.
// Configuration writes of zero, to an index above one, or while tokens are
// held, are dropped.
module timed_token_pipeline_queue #(
    parameter int MAX_IN_FLIGHT = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tq_pkg::CFG_W-1:0]     cfg_data,
    tq_in_if.sink                        in_ch,
    tq_out_if.source                     out_ch
);
    import tq_pkg::*;

    localparam int OCC_W = $clog2(MAX_IN_FLIGHT + 1);

    tq_cmd_t cmd;

    tq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_ready (out_ch.ready),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd)
    );

    tq_datapath #(
        .MAX_IN_FLIGHT (MAX_IN_FLIGHT),
        .OCC_W         (OCC_W)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .opcode           (in_ch.opcode),
        .command_id       (in_ch.command_id),
        .element_index    (in_ch.element_index),
        .last_flag        (in_ch.last_flag),
        .now              (in_ch.now),
        .status           (out_ch.status),
        .token_valid      (out_ch.token_valid),
        .token_command_id (out_ch.token_command_id),
        .token_index      (out_ch.token_index),
        .token_last       (out_ch.token_last),
        .in_flight        (out_ch.in_flight),
        .can_accept_now   (out_ch.can_accept_now),
        .queue_full       (out_ch.queue_full),
        .head_ready       (out_ch.head_ready)
    );

endmodule

// ----- src/tq_ctrl.sv -----
// Controller of the timed token pipeline queue: steps one transaction through
// latch, time add, execute, settle, flag and response phases. Uses tq_pkg.
module tq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_ready,
    output logic            in_ready,
    output logic            out_valid,
    output tq_pkg::tq_cmd_t cmd
);
    import tq_pkg::*;

    tq_state_t state_reg, state_next;

    // Hold or advance the phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next phase
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_PREP;
            S_PREP:   state_next = S_EXEC;
            S_EXEC:   state_next = S_SETTLE;
            S_SETTLE: state_next = S_FLAGS;
            S_FLAGS:  state_next = S_RESP;
            S_RESP:   if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Handshake and datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_PREP:   cmd.do_prep  = 1'b1;
            S_EXEC:   cmd.do_exec  = 1'b1;
            S_SETTLE: ;
            S_FLAGS:  cmd.do_flags = 1'b1;
            S_RESP:   out_valid    = 1'b1;
            default:  ;
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_exec_follows_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_prep |=> cmd.do_exec)
        else $error("execute phase did not follow time add");

    a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

// ----- src/tq_datapath.sv -----
// Datapath of the timed token pipeline queue: slot memory, pointers, occupancy,
// interval gate, configuration registers and result register. Uses tq_pkg.
module tq_datapath #(
    parameter int MAX_IN_FLIGHT = 16,
    parameter int PTR_W = (MAX_IN_FLIGHT > 1) ? $clog2(MAX_IN_FLIGHT) : 1,
    parameter int OCC_W = $clog2(MAX_IN_FLIGHT + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tq_pkg::tq_cmd_t                cmd,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [tq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tq_pkg::CFG_W-1:0]       cfg_data,
    // request fields
    input  logic [tq_pkg::OPCODE_W-1:0]    opcode,
    input  logic [tq_pkg::CMD_ID_W-1:0]    command_id,
    input  logic [tq_pkg::INDEX_W-1:0]     element_index,
    input  logic                           last_flag,
    input  logic [tq_pkg::TIME_W-1:0]      now,
    // result fields
    output logic [tq_pkg::STATUS_W-1:0]    status,
    output logic                           token_valid,
    output logic [tq_pkg::CMD_ID_W-1:0]    token_command_id,
    output logic [tq_pkg::INDEX_W-1:0]     token_index,
    output logic                           token_last,
    output logic [OCC_W-1:0]               in_flight,
    output logic                           can_accept_now,
    output logic                           queue_full,
    output logic                           head_ready
);
    import tq_pkg::*;

    localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(MAX_IN_FLIGHT);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_IN_FLIGHT - 1);

    // Slot memory, one write port at the tail, registered read at the head
    tq_slot_t mem [MAX_IN_FLIGHT];
    tq_slot_t rd_reg;

    // Latched request
    tq_op_t             op_reg;
    logic [CMD_ID_W-1:0] cid_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic                last_reg;
    logic [TIME_W-1:0]   now_reg;

    // Precomputed times
    logic [TIME_W-1:0] ready_time_reg;
    logic [TIME_W-1:0] gate_time_reg;

    // Queue and gate state
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              armed_reg, armed_next;
    logic [TIME_W-1:0] nat_reg, nat_next;
    logic [CFG_W-1:0]  fill_lat_reg;
    logic [CFG_W-1:0]  ii_reg;

    // Result register
    tq_status_t          status_reg, status_next;
    logic                tvalid_reg, tvalid_next;
    logic [CMD_ID_W-1:0] tcid_reg;
    logic [INDEX_W-1:0]  tidx_reg;
    logic                tlast_reg;
    logic                can_acc_reg;
    logic                full_reg;
    logic                head_rdy_reg;

    logic push;
    logic full_now;
    logic gate_elapsed;
    logic head_ok;

    // Latch the request on acceptance and add the delays to its timestamp in time add
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= tq_op_t'(opcode);
            cid_reg  <= command_id;
            idx_reg  <= element_index;
            last_reg <= last_flag;
            now_reg  <= now;
        end
        if (cmd.do_prep)
        begin
            ready_time_reg <= sat_add(now_reg, fill_lat_reg);
            gate_time_reg  <= sat_add(now_reg, ii_reg);
        end
    end

    // Shared checks against the current state
    assign full_now     = (occ_reg >= OCC_MAX);
    assign gate_elapsed = !armed_reg || (now_reg >= nat_reg);
    assign head_ok      = (occ_reg != '0) && (rd_reg.ready_time <= now_reg);

    // Decide the operation
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        armed_next  = armed_reg;
        nat_next    = nat_reg;
        status_next = ST_OK;
        tvalid_next = 1'b0;
        push        = 1'b0;
        unique case (op_reg)
            OP_ACCEPT_GATED:
            begin
                if (full_now)
                begin
                    status_next = ST_REFUSED_FULL;
                end
                else if (!gate_elapsed)
                begin
                    status_next = ST_REFUSED_GATE;
                end
                else
                begin
                    push       = 1'b1;
                    armed_next = 1'b1;
                    nat_next   = gate_time_reg;
                end
            end
            OP_ACCEPT_ADD:
            begin
                if (full_now)
                begin
                    status_next = ST_REFUSED_FULL;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            OP_TAKE_READY:
            begin
                if (!head_ok)
                begin
                    status_next = ST_NOTHING_READY;
                end
                else
                begin
                    tvalid_next = 1'b1;
                    head_next   = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    occ_next    = occ_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                occ_next   = '0;
                armed_next = 1'b0;
                nat_next   = '0;
            end
            default: ;
        endcase
        if (push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            occ_next  = occ_reg + 1'b1;
        end
    end

    // Write the tail slot and read the head slot
    always_ff @(posedge clk)
    begin
        if (cmd.do_exec && push)
        begin
            mem[tail_reg] <= '{command_id: cid_reg, element_index: idx_reg,
                               last_mark: last_reg, ready_time: ready_time_reg};
        end
        rd_reg <= mem[head_reg];
    end

    // Update queue, gate and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            armed_reg    <= 1'b0;
            nat_reg      <= '0;
            fill_lat_reg <= CFG_W'(1);
            ii_reg       <= CFG_W'(1);
        end
        else
        begin
            if (cmd.do_exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                occ_reg   <= occ_next;
                armed_reg <= armed_next;
                nat_reg   <= nat_next;
            end
            // Drop zero writes and writes while tokens are held
            if (cfg_we && (cfg_data != '0) && (occ_reg == '0))
            begin
                if (cfg_index == CFG_FILL_LATENCY)
                begin
                    fill_lat_reg <= cfg_data;
                end
                else if (cfg_index == CFG_INIT_INTERVAL)
                begin
                    ii_reg <= cfg_data;
                end
            end
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (cmd.do_exec)
        begin
            status_reg <= status_next;
            tvalid_reg <= tvalid_next;
            tcid_reg   <= tvalid_next ? rd_reg.command_id : '0;
            tidx_reg   <= tvalid_next ? rd_reg.element_index : '0;
            tlast_reg  <= tvalid_next && rd_reg.last_mark;
        end
        if (cmd.do_flags)
        begin
            can_acc_reg  <= !full_now && gate_elapsed;
            full_reg     <= full_now;
            head_rdy_reg <= head_ok;
        end
    end

    assign status           = status_reg;
    assign token_valid      = tvalid_reg;
    assign token_command_id = tcid_reg;
    assign token_index      = tidx_reg;
    assign token_last       = tlast_reg;
    assign in_flight        = occ_reg;
    assign can_accept_now   = can_acc_reg;
    assign queue_full       = full_reg;
    assign head_ready       = head_rdy_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_MAX)
        else $error("occupancy above queue depth");

    a_state_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.do_exec |=> ($stable(occ_reg) && $stable(head_reg) && $stable(tail_reg)))
        else $error("queue state moved outside the execute phase");

    a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

endmodule
